[rtl/core/hmtm_pkg.sv]
// ----------------------------------------------------------------------------
// hmtm_pkg
// Method word table, codes and shared types for the HTTP method matcher.
// ----------------------------------------------------------------------------
package hmtm_pkg;

   localparam int WORD_COUNT = 27;
   localparam int WORD_MAX   = 16;
   localparam int TEXT_W     = WORD_MAX * 8;
   localparam int POS_W      = 5;
   localparam int CODE_W     = 5;

   localparam logic [POS_W-1:0]  POS_SAT      = POS_W'(17);
   localparam logic [7:0]        CHAR_SPACE   = 8'h20;
   localparam logic [CODE_W-1:0] CODE_UNKNOWN = '0;

   typedef logic [WORD_COUNT-1:0] mask_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [CODE_W-1:0]     code_type;

   // words are right-justified: last character in the low byte
   localparam logic [TEXT_W-1:0] WORD_TEXT [WORD_COUNT] = '{
      TEXT_W'("GET"), TEXT_W'("HEAD"), TEXT_W'("PUT"), TEXT_W'("POST"),
      TEXT_W'("MOVE"), TEXT_W'("LOCK"), TEXT_W'("COPY"),
      TEXT_W'("PATCH"), TEXT_W'("MERGE"), TEXT_W'("MKCOL"), TEXT_W'("LABEL"),
      TEXT_W'("TRACE"),
      TEXT_W'("UNLOCK"), TEXT_W'("UPDATE"), TEXT_W'("REPORT"), TEXT_W'("DELETE"),
      TEXT_W'("OPTIONS"), TEXT_W'("CONNECT"), TEXT_W'("CHECKIN"),
      TEXT_W'("PROPFIND"), TEXT_W'("CHECKOUT"), TEXT_W'("PROPPATCH"),
      TEXT_W'("UNCHECKOUT"), TEXT_W'("MKACTIVITY"), TEXT_W'("MKWORKSPACE"),
      TEXT_W'("VERSION-CONTROL"), TEXT_W'("BASELINE-CONTROL")
   };

   localparam logic [POS_W-1:0] WORD_LEN [WORD_COUNT] = '{
      5'd3, 5'd4, 5'd3, 5'd4, 5'd4, 5'd4, 5'd4,
      5'd5, 5'd5, 5'd5, 5'd5, 5'd5,
      5'd6, 5'd6, 5'd6, 5'd6,
      5'd7, 5'd7, 5'd7,
      5'd8, 5'd8, 5'd9,
      5'd10, 5'd10, 5'd11,
      5'd15, 5'd16
   };

   localparam logic [CODE_W-1:0] WORD_CODE [WORD_COUNT] = '{
      5'd1, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
      5'd7, 5'd8, 5'd9, 5'd10, 5'd11,
      5'd12, 5'd13, 5'd14, 5'd15,
      5'd16, 5'd17, 5'd18,
      5'd19, 5'd20, 5'd21,
      5'd22, 5'd23, 5'd24,
      5'd25, 5'd26
   };

   typedef struct packed {
      mask_type mask;
      pos_type  pos;
      code_type code;
   } match_type;

endpackage

[rtl/core/hmtm_matcher.sv]
// ----------------------------------------------------------------------------
// hmtm_matcher
// Narrows the candidate mask by one byte and resolves the method code for
// either the current token (space) or the token extended by this byte.
// ----------------------------------------------------------------------------
module hmtm_matcher
   import hmtm_pkg::*;
(
   input  mask_type   mask,
   input  pos_type    pos,
   input  logic [7:0] char_byte,
   input  logic       is_space,
   output match_type  result
);

   mask_type   narrow_mask;
   pos_type    narrow_pos;
   mask_type   sel_mask;
   pos_type    sel_pos;
   code_type   code;
   logic [3:0] offset [WORD_COUNT];

   always_comb begin
      for (int i = 0; i < WORD_COUNT; i++) begin
         offset[i] = WORD_LEN[i][3:0] - 4'd1 - pos[3:0];
         narrow_mask[i] = mask[i] && (pos < WORD_LEN[i]) &&
                          (WORD_TEXT[i][{offset[i], 3'b000} +: 8] == char_byte);
      end
      narrow_pos = (pos < POS_SAT) ? pos + POS_W'(1) : pos;
   end

   assign sel_mask = is_space ? mask : narrow_mask;
   assign sel_pos  = is_space ? pos  : narrow_pos;

   // at most one word matches exactly, so an OR of codes suffices
   always_comb begin
      code = CODE_UNKNOWN;
      for (int i = 0; i < WORD_COUNT; i++) begin
         if (sel_mask[i] && (WORD_LEN[i] == sel_pos)) begin
            code = code | WORD_CODE[i];
         end
      end
   end

   assign result.mask = narrow_mask;
   assign result.pos  = narrow_pos;
   assign result.code = code;

endmodule

[rtl/core/http_method_token_matcher.sv]
// ----------------------------------------------------------------------------
// http_method_token_matcher
// Exact lookup of the HTTP/WebDAV request method at the head of a buffer.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle and the code is registered for the
// result; the only limit is the result register itself, which holds the
// input off only while a code waits and the receiver stalls. The token ends
// at the first space or at the byte marked last; one method code is given
// then (0 for an unknown, empty or over-long token, HEAD reports as GET).
// Bytes after the token give nothing, and the byte marked last re-arms the
// matcher for the next buffer.
module http_method_token_matcher
   import hmtm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_method_code
);

   mask_type  mask_ff, mask_in;
   pos_type   pos_ff, pos_in;
   logic      done_ff, done_in;
   logic      rsp_valid_ff, rsp_valid_in;
   code_type  rsp_code_ff, rsp_code_in;
   logic      accept;
   logic      is_space;
   logic      emit;
   match_type match;

   hmtm_matcher u_matcher (
      .mask      (mask_ff),
      .pos       (pos_ff),
      .char_byte (req_char_byte),
      .is_space  (is_space),
      .result    (match)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_space  = (req_char_byte == CHAR_SPACE);

   always_comb begin
      mask_in = mask_ff;
      pos_in  = pos_ff;
      done_in = done_ff;
      emit    = 1'b0;
      if (accept) begin
         priority if (done_ff) begin
            if (req_last_byte) begin
               mask_in = '1;
               pos_in  = '0;
               done_in = 1'b0;
            end
         end else if (is_space) begin
            emit = 1'b1;
            if (req_last_byte) begin
               mask_in = '1;
               pos_in  = '0;
               done_in = 1'b0;
            end else begin
               done_in = 1'b1;
            end
         end else begin
            if (req_last_byte) begin
               emit    = 1'b1;
               mask_in = '1;
               pos_in  = '0;
            end else begin
               mask_in = match.mask;
               pos_in  = match.pos;
            end
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   assign rsp_code_in  = emit ? match.code : rsp_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '1;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         pos_ff       <= pos_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_method_code = rsp_code_ff;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the HTTP method token matcher.
// ----------------------------------------------------------------------------
// Feeds buffers one byte per item. Most buffers are real method words
// (exact, mutated, truncated or extended), the rest are over-long tokens,
// empty tokens and raw noise. Each accepted byte steps a predictor that
// narrows its own word mask and queues the code due when the token ends.
// Results are checked in order against that queue. Both sides idle at
// random, and the receiver holds off for long stretches now and then so
// that the matcher has to stall its input.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hmtm_pkg::*;

   typedef logic [7:0] byte_q [$];

   class method_scoreboard;
      string       word_text [WORD_COUNT];
      code_type    word_code [WORD_COUNT];
      mask_type    live_words;
      pos_type     token_pos;
      bit          token_ended;
      code_type    expected_codes [$];
      int          mismatches;
      int          codes_checked;
      logic [31:0] codes_seen;

      function new();
         word_text = '{"GET", "HEAD", "PUT", "POST", "MOVE", "LOCK", "COPY",
                       "PATCH", "MERGE", "MKCOL", "LABEL", "TRACE",
                       "UNLOCK", "UPDATE", "REPORT", "DELETE",
                       "OPTIONS", "CONNECT", "CHECKIN",
                       "PROPFIND", "CHECKOUT", "PROPPATCH",
                       "UNCHECKOUT", "MKACTIVITY", "MKWORKSPACE",
                       "VERSION-CONTROL", "BASELINE-CONTROL"};
         word_code = '{5'd1, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
                       5'd7, 5'd8, 5'd9, 5'd10, 5'd11,
                       5'd12, 5'd13, 5'd14, 5'd15,
                       5'd16, 5'd17, 5'd18,
                       5'd19, 5'd20, 5'd21,
                       5'd22, 5'd23, 5'd24,
                       5'd25, 5'd26};
         mismatches    = 0;
         codes_checked = 0;
         codes_seen    = '0;
         rearm();
      endfunction

      function void rearm();
         live_words  = '1;
         token_pos   = '0;
         token_ended = 1'b0;
      endfunction

      function code_type matched_code();
         int i;
         for (i = 0; i < WORD_COUNT; i++) begin
            if (live_words[i] && word_text[i].len() == token_pos) return word_code[i];
         end
         return CODE_UNKNOWN;
      endfunction

      // returns 1 unless the byte is a trailing one, not marked last, that the matcher just drops
      function bit note_byte(logic [7:0] b, bit last);
         int i;
         if (token_ended) begin
            if (last) rearm();
            return last;
         end
         if (b == CHAR_SPACE) begin
            expected_codes.push_back(matched_code());
            if (last) rearm();
            else token_ended = 1'b1;
            return 1'b1;
         end
         for (i = 0; i < WORD_COUNT; i++) begin
            if (!(token_pos < word_text[i].len() && token_pos < WORD_MAX &&
                  8'(word_text[i][token_pos]) == b))
               live_words[i] = 1'b0;
         end
         if (token_pos < POS_SAT) token_pos++;
         if (last) begin
            expected_codes.push_back(matched_code());
            rearm();
         end
         return 1'b1;
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_code(code_type got);
         code_type want;
         if (expected_codes.size() == 0) begin
            report($sformatf("method code %0d with none expected", got));
            return;
         end
         want = expected_codes.pop_front();
         codes_checked++;
         codes_seen[want] = 1'b1;
         if (got !== want) report($sformatf("method code %0d, want %0d", got, want));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [4:0] rsp_method_code;

   method_scoreboard board;
   bit idle_free    = 1'b0;
   bit hold_request = 1'b0;
   int items_sent   = 0;
   int buffers_sent = 0;

   http_method_token_matcher dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_byte   (req_char_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_method_code (rsp_method_code)
   );

   always #10 clock = ~clock;

   function automatic byte_q str_bytes(string s);
      byte_q q;
      int    i;
      for (i = 0; i < s.len(); i++) q.push_back(8'(s[i]));
      return q;
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit last);
      int gap;
      gap = idle_free ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      if (board.note_byte(b, last)) items_sent++;
   endtask

   task automatic send_buffer(input byte_q data);
      int i;
      for (i = 0; i < data.size(); i++) send_byte(data[i], i == data.size() - 1);
      buffers_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_code(rsp_method_code);
   end

   // result side
   initial begin
      int n;
      rsp_stall = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         n = idle_free ? 0 : $urandom_range(0, 3);
         if (hold_request) begin
            hold_request = 1'b0;
            n = 40;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #4_000_000;
      $display("timeout: %0d codes still expected", board.expected_codes.size());
      $display("http_method_token_matcher verification failed");
      $finish;
   end

   initial begin
      byte_q buffer_bytes;
      int    kind;
      int    pick;
      int    p;
      int    n;
      int    w;
      int    hold_count;
      int    waited;
      int    distinct;
      board         = new();
      hold_count    = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_byte = 8'h00;
      req_last_byte = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: last inside token, lone space, trailing bytes, case,
      // NUL and top byte values, space carrying last
      send_buffer(str_bytes("HEAD"));
      send_buffer(str_bytes(" "));
      send_buffer(str_bytes("PUT Z"));
      send_buffer(str_bytes("lock"));
      send_buffer('{8'h00, 8'hFF});
      send_buffer(str_bytes("GET "));

      while (items_sent < 1250) begin
         if ($urandom_range(0, 19) == 0) idle_free = !idle_free;
         if (hold_count < 3 && items_sent >= 300 + 350 * hold_count) begin
            hold_request = 1'b1;
            hold_count++;
         end
         kind = $urandom_range(0, 99);
         w    = $urandom_range(0, WORD_COUNT - 1);
         buffer_bytes = {};
         if (kind < 70) begin
            buffer_bytes = str_bytes(board.word_text[w]);
            if (kind >= 55) begin
               pick = $urandom_range(0, 3);
               p    = $urandom_range(0, buffer_bytes.size() - 1);
               case (pick)
                  0: buffer_bytes[p] = 8'($urandom_range(0, 255));
                  1: void'(buffer_bytes.pop_back());
                  2: buffer_bytes.push_back(8'($urandom_range(0, 255)));
                  default: buffer_bytes[p] = buffer_bytes[p] ^ 8'h20;
               endcase
            end
         end else if (kind < 78) begin
            n = $urandom_range(POS_SAT, 22);
            if (kind < 74) buffer_bytes = str_bytes(board.word_text[WORD_COUNT - 1]);
            while (buffer_bytes.size() < n) begin
               p = $urandom_range(0, 255);
               if (p != CHAR_SPACE) buffer_bytes.push_back(8'(p));
            end
         end else if (kind >= 84) begin
            n = $urandom_range(1, 8);
            repeat (n) buffer_bytes.push_back(8'($urandom_range(0, 255)));
         end
         if (kind < 84 && (kind >= 78 || $urandom_range(0, 1) == 1)) begin
            buffer_bytes.push_back(CHAR_SPACE);
            n = $urandom_range(0, 3);
            repeat (n) buffer_bytes.push_back(8'($urandom_range(0, 255)));
         end
         send_buffer(buffer_bytes);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (board.expected_codes.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (board.expected_codes.size() != 0)
         board.report($sformatf("%0d method codes never arrived",
                                board.expected_codes.size()));

      distinct = $countones(board.codes_seen);
      $display("Sent %0d buffers (%0d bytes that mattered), with long result hold-offs.",
               buffers_sent, items_sent);
      $display("Checked %0d method codes, %0d distinct values; %0d mismatches.",
               board.codes_checked, distinct, board.mismatches);
      if (board.mismatches == 0) begin
         $display("http_method_token_matcher verification clean");
      end else begin
         $display("http_method_token_matcher verification failed");
      end
      $finish;
   end

endmodule
